[src/rms_sound_level_detector_assert.svh]
// assertion macros for the rms sound level detector
// both sample at the rising edge of the given clock and are off during reset

`ifndef RMS_SOUND_LEVEL_DETECTOR_ASSERT_SVH
`define RMS_SOUND_LEVEL_DETECTOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define RSLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsld assertion failed");

// consequent holds in the cycle after the antecedent
`define RSLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsld assertion failed");

`endif

[src/rsld_pkg.sv]
// ----------------------------------------------------------------------------
// rsld_pkg
// shared widths, codes and types of the rms sound level detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsld_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 7;
   localparam int SUM_W       = 40;   // square sum and divider dividend
   localparam int SQ_W        = 32;   // square of a 16-bit magnitude
   localparam int ROOT_W      = SUM_W / 2;
   localparam int STEP_W      = 24;   // shared compare-subtract width
   localparam int FULL_SCALE_LOG2 = 14;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 7'd50;

   typedef logic [CSR_ADDR_W-3:0] csr_idx_type;
   localparam csr_idx_type REG_THRESHOLD = 1'b0;

   // input op codes
   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;

   // result kind codes
   localparam logic KIND_LEVEL = 1'b0;
   localparam logic KIND_CAL   = 1'b1;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

`default_nettype wire

[src/rsld_if.sv]
// ----------------------------------------------------------------------------
// rsld_req_if / rsld_rsp_if
// valid/ready channels for samples in and results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rsld_req_if;
   logic                   valid;
   logic                   ready;
   logic                   op;
   rsld_pkg::sample_type   sample;
   logic                   last;

   modport source (output valid, output op, output sample, output last, input ready);
   modport sink (input valid, input op, input sample, input last, output ready);
endinterface

interface rsld_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   kind;
   rsld_pkg::level_type    level;
   logic                   detected;
   logic                   changed;
   rsld_pkg::sample_type   noise_floor;

   modport source (output valid, output kind, output level, output detected,
                   output changed, output noise_floor, input ready);
   modport sink (input valid, input kind, input level, input detected,
                 input changed, input noise_floor, output ready);
endinterface

`default_nettype wire

[src/rsld_cmp_sub.sv]
// ----------------------------------------------------------------------------
// rsld_cmp_sub
// shared compare and subtract unit for the divide and square root steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsld_cmp_sub #(
   parameter int W = 24
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic              ge,
   output logic [W-1:0]      diff
);

   logic [W:0] wide;

   // borrow out of the extended subtract means a < b
   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[W];
   assign diff = wide[W-1:0];

endmodule

`default_nettype wire

[src/rsld_csr.sv]
// ----------------------------------------------------------------------------
// rsld_csr
// apb register file holding the detect threshold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsld_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rsld_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rsld_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rsld_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output rsld_pkg::level_type                  threshold
);
   import rsld_pkg::*;

   level_type   thr_ff, thr_in;
   csr_idx_type idx;
   level_type   wval;
   logic        wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wval       = csr_pwdata[LEVEL_W-1:0];

   always_comb begin
      thr_in = thr_ff;
      if (wr_en && (idx == REG_THRESHOLD)) begin
         // values above full scale saturate
         thr_in = (wval > LEVEL_MAX) ? LEVEL_MAX : wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RST;
      end else begin
         thr_ff <= thr_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == REG_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(thr_ff);
      end
   end

   assign threshold = thr_ff;

endmodule

`default_nettype wire

[src/rms_sound_level_detector.sv]
// ----------------------------------------------------------------------------
// rms_sound_level_detector
// rms level meter with noise floor removal over blocks of audio samples
// ----------------------------------------------------------------------------
// usage:
//  - req_chan carries one sample per transaction (op, sample, last); op selects
//    measure or calibrate, last closes a block or a calibration run
//  - rsp_chan gives one result transaction for each sample with last set:
//    a level result (level, detected, changed) or a calibration result, both
//    with the noise floor in use
//  - csr port: apb, register 0 at byte address 0 is the detect threshold
//  - a sample without last: the square is formed at accept, and the sum is
//    updated in the next cycle
//  - a measure block end runs 40 restoring divide steps and 20 square root
//    steps, all through one shared compare-subtract unit, plus load, scale
//    and finish states; a calibration end runs only load, divide and finish
//  - the block takes no sample while it works on one
//  - the result sits in an output register; a stalled receiver holds the
//    block only when a new result is ready and the register is still full
//  - synchronous reset clears the floor, the sums, the counts, the detect
//    flag and sets the threshold to 50
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rms_sound_level_detector_assert.svh"

module rms_sound_level_detector #(
   parameter int MAX_BLOCK = 256,
   parameter int CAL_MAX   = 16384
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rsld_req_if.sink                             req_chan,
   rsld_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rsld_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rsld_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rsld_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import rsld_pkg::*;

   // counter and accumulator widths follow the run limits
   localparam int BLK_W     = $clog2(MAX_BLOCK + 1);
   localparam int CAL_W     = $clog2(CAL_MAX + 1);
   localparam int CAL_SUM_W = SAMPLE_W + CAL_W;
   localparam int DVR_W     = (BLK_W > CAL_W) ? BLK_W : CAL_W;
   localparam int IT_W      = $clog2(SUM_W);
   localparam int PROD_W    = ROOT_W + LEVEL_W;

   localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(SUM_W - 1);
   localparam logic [IT_W-1:0] ROOT_LAST = IT_W'(ROOT_W - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ACCUM = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_LEVEL = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;

   // latched sample transaction
   logic                  op_ff, last_ff;
   sample_type            smp_ff;
   logic [SQ_W-1:0]       sq_ff;

   // architectural state
   sample_type            floor_ff, floor_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [BLK_W-1:0]      blk_cnt_ff, blk_cnt_in;
   logic [CAL_SUM_W-1:0]  cal_sum_ff, cal_sum_in;
   logic [CAL_W-1:0]      cal_cnt_ff, cal_cnt_in;
   logic                  det_flag_ff, det_flag_in;

   // iterative divide / root datapath
   logic [SUM_W-1:0]      num_ff, num_in;
   logic [STEP_W-1:0]     rem_ff, rem_in;
   logic [DVR_W-1:0]      dvr_ff, dvr_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [IT_W-1:0]       it_ff, it_in;
   level_type             level_ff, level_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff, kind_in;
   level_type             rlevel_ff, rlevel_in;
   logic                  det_ff, det_in;
   logic                  chg_ff, chg_in;
   sample_type            rfloor_ff, rfloor_in;

   level_type             threshold;
   logic                  req_fire;
   logic                  slot_free;

   // square of the difference from the floor, formed at accept
   logic signed [SAMPLE_W:0] diff;
   logic [SAMPLE_W:0]        mag;
   logic [SQ_W-1:0]          sq_in;

   logic [SUM_W:0]           sum_wide;
   logic [CAL_SUM_W-1:0]     cal_mag;
   logic [SAMPLE_W-1:0]      mean_mag;
   sample_type               mean;
   logic [PROD_W-1:0]        prod;
   logic [PROD_W-FULL_SCALE_LOG2-1:0] lvl_raw;

   // shared unit operands
   logic [STEP_W-1:0]     cs_a, cs_b, cs_diff;
   logic                  cs_ge;

   rsld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   rsld_cmp_sub #(.W(STEP_W)) u_cmp_sub (
      .a    (cs_a),
      .b    (cs_b),
      .ge   (cs_ge),
      .diff (cs_diff)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign diff  = {req_chan.sample[SAMPLE_W-1], req_chan.sample}
                - {floor_ff[SAMPLE_W-1], floor_ff};
   assign mag   = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;
   assign sq_in = mag[SAMPLE_W-1:0] * mag[SAMPLE_W-1:0];

   // saturating add into the square sum
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);

   // magnitude of the calibration sum for the unsigned divider
   assign cal_mag = cal_sum_ff[CAL_SUM_W-1] ? -cal_sum_ff : cal_sum_ff;

   // divide step shifts in one dividend bit, root step shifts in two
   always_comb begin
      if (state_ff == ST_ROOT) begin
         cs_a = {rem_ff[STEP_W-3:0], num_ff[SUM_W-1 -: 2]};
         cs_b = STEP_W'({root_ff, 2'b01});
      end else begin
         cs_a = {rem_ff[STEP_W-2:0], num_ff[SUM_W-1]};
         cs_b = STEP_W'(dvr_ff);
      end
   end

   // rms scaled to 0..100
   assign prod    = root_ff * PROD_W'(LEVEL_MAX);
   assign lvl_raw = prod[PROD_W-1:FULL_SCALE_LOG2];

   // mean truncated toward zero
   assign mean_mag = num_ff[SAMPLE_W-1:0];
   assign mean     = cal_sum_ff[CAL_SUM_W-1] ? -mean_mag : mean_mag;

   always_comb begin
      state_in     = state_ff;
      floor_in     = floor_ff;
      sum_in       = sum_ff;
      blk_cnt_in   = blk_cnt_ff;
      cal_sum_in   = cal_sum_ff;
      cal_cnt_in   = cal_cnt_ff;
      det_flag_in  = det_flag_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvr_in       = dvr_ff;
      root_in      = root_ff;
      it_in        = it_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      rlevel_in    = rlevel_ff;
      det_in       = det_ff;
      chg_in       = chg_ff;
      rfloor_in    = rfloor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (op_ff == OP_MEASURE) begin
               // samples beyond the block limit are dropped
               if (blk_cnt_ff < BLK_W'(MAX_BLOCK)) begin
                  sum_in     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                  blk_cnt_in = blk_cnt_ff + 1'b1;
               end
            end else begin
               if (cal_cnt_ff < CAL_W'(CAL_MAX)) begin
                  cal_sum_in = cal_sum_ff
                             + {{(CAL_SUM_W-SAMPLE_W){smp_ff[SAMPLE_W-1]}}, smp_ff};
                  cal_cnt_in = cal_cnt_ff + 1'b1;
               end
            end
            state_in = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            rem_in = '0;
            it_in  = DIV_LAST;
            if (op_ff == OP_MEASURE) begin
               num_in = sum_ff;
               dvr_in = DVR_W'(blk_cnt_ff);
            end else begin
               num_in = SUM_W'(cal_mag);
               dvr_in = DVR_W'(cal_cnt_ff);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, quotient bits shift into the dividend word
            rem_in = cs_ge ? cs_diff : cs_a;
            num_in = {num_ff[SUM_W-2:0], cs_ge};
            it_in  = it_ff - 1'b1;
            if (it_ff == '0) begin
               if (op_ff == OP_MEASURE) begin
                  rem_in   = '0;
                  root_in  = '0;
                  it_in    = ROOT_LAST;
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT: begin
            // digit by digit integer square root of the quotient
            rem_in  = cs_ge ? cs_diff : cs_a;
            root_in = {root_ff[ROOT_W-2:0], cs_ge};
            num_in  = {num_ff[SUM_W-3:0], 2'b00};
            it_in   = it_ff - 1'b1;
            if (it_ff == '0) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            level_in = (lvl_raw > (PROD_W - FULL_SCALE_LOG2)'(LEVEL_MAX)) ?
                       LEVEL_MAX : lvl_raw[LEVEL_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_MEASURE) begin
                  kind_in     = KIND_LEVEL;
                  rlevel_in   = level_ff;
                  det_in      = (level_ff >= threshold);
                  chg_in      = (level_ff >= threshold) != det_flag_ff;
                  det_flag_in = (level_ff >= threshold);
                  rfloor_in   = floor_ff;
                  sum_in      = '0;
                  blk_cnt_in  = '0;
               end else begin
                  kind_in    = KIND_CAL;
                  rlevel_in  = '0;
                  det_in     = 1'b0;
                  chg_in     = 1'b0;
                  floor_in   = mean;
                  rfloor_in  = mean;
                  cal_sum_in = '0;
                  cal_cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floor_ff     <= '0;
         sum_ff       <= '0;
         blk_cnt_ff   <= '0;
         cal_sum_ff   <= '0;
         cal_cnt_ff   <= '0;
         det_flag_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         it_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         sum_ff       <= sum_in;
         blk_cnt_ff   <= blk_cnt_in;
         cal_sum_ff   <= cal_sum_in;
         cal_cnt_ff   <= cal_cnt_in;
         det_flag_ff  <= det_flag_in;
         rsp_valid_ff <= rsp_valid_in;
         it_ff        <= it_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_chan.op;
         smp_ff  <= req_chan.sample;
         last_ff <= req_chan.last;
         sq_ff   <= sq_in;
      end
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      dvr_ff    <= dvr_in;
      root_ff   <= root_in;
      level_ff  <= level_in;
      kind_ff   <= kind_in;
      rlevel_ff <= rlevel_in;
      det_ff    <= det_in;
      chg_ff    <= chg_in;
      rfloor_ff <= rfloor_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.level       = rlevel_ff;
   assign rsp_chan.detected    = det_ff;
   assign rsp_chan.changed     = chg_ff;
   assign rsp_chan.noise_floor = rfloor_ff;

   // an accepted sample always moves the sequencer to the accumulate state next
   `RSLD_ASSERT_NEXT(a_accept_accum, clock, reset, req_fire, state_ff == ST_ACCUM)
   // block count never passes the block limit
   `RSLD_ASSERT_NOW(a_blk_cnt_max, clock, reset, 1'b1, blk_cnt_ff <= BLK_W'(MAX_BLOCK))
   // a finished result waits while the output register is held
   `RSLD_ASSERT_NEXT(a_done_waits, clock, reset,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_chan.ready, state_ff == ST_DONE)
   // level results stay in range, calibration results carry no level flags
   `RSLD_ASSERT_NOW(a_rsp_fields, clock, reset, rsp_valid_ff,
      (rlevel_ff <= LEVEL_MAX) && ((kind_ff == KIND_LEVEL) || (!det_ff && !chg_ff)))

endmodule

`default_nettype wire
